// ===== src/rarst_pkg.sv =====
`timescale 1ns / 1ps

package rarst_pkg;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUM = 1'b1;

    localparam int IDX_W = 10;
    localparam int AMT_W = 32;
    localparam int SUM_W = 64;

    // one classified command as it sits in the queue
    typedef struct packed {
        logic             is_sum;
        logic             empty;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [SUM_W-1:0] amt;
    } rarst_cmd_t;

endpackage

// ===== src/range_add_range_sum_tree_unit.sv =====
`timescale 1ns / 1ps

// range add / range sum store over LEAVES signed 64-bit totals, all zero after
// reset. cmd 0 adds add_amount to every position of [range_low, range_high]
// and gives no beat; cmd 1 gives one range_sum beat, the wrapped 64-bit sum.
// an empty range changes nothing and sums to zero; positions at or above
// LEAVES are clipped off. the front classifies commands into a two-entry
// queue; the back walks two binary-indexed trees held in memories with
// registered reads. a command is accepted, then handled as up to two points;
// each point takes a read and a step per tree node visited, a split multiply
// in 32-bit halves and a finishing step; an empty add goes straight to idle.
// a sum beat is then held until taken. after reset the back clears its memories,
// one entry a cycle; meanwhile the queue may fill but the back takes nothing.
module range_add_range_sum_tree_unit
    import rarst_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    cmd,
    input  logic [IDX_W-1:0]        range_low,
    input  logic [IDX_W-1:0]        range_high,
    input  logic signed [AMT_W-1:0] add_amount,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] range_sum
);

    rarst_cmd_t       q_data;
    logic             q_valid, q_ready, busy;
    logic [SUM_W-1:0] sum_w;

    rarst_front #(.LEAVES(LEAVES), .DEPTH(2)) u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .range_low(range_low), .range_high(range_high),
        .add_amount(add_amount),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    rarst_back #(.LEAVES(LEAVES)) u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .range_sum(sum_w), .busy(busy)
    );

    assign range_sum = sum_w;

    // a result beat only while the back is busy
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result without active command");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(range_sum))
        else $error("result changed while stalled");

    // back takes from the queue only when idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> !out_valid)
        else $error("queue pop while result pending");

endmodule

// ===== src/rarst_front.sv =====
`timescale 1ns / 1ps

module rarst_front
    import rarst_pkg::*;
#(
    parameter int LEAVES = 1024,
    parameter int DEPTH  = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    cmd,
    input  logic [IDX_W-1:0]        range_low,
    input  logic [IDX_W-1:0]        range_high,
    input  logic signed [AMT_W-1:0] add_amount,
    output logic                    q_valid,
    input  logic                    q_ready,
    output rarst_cmd_t              q_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // last reachable position, saturated to the index range
    localparam int LAST_I = (LEAVES > (1 << IDX_W)) ? (1 << IDX_W) - 1 : LEAVES - 1;
    localparam logic [IDX_W:0] LAST = (IDX_W+1)'(LAST_I);

    rarst_cmd_t        fifo_reg [DEPTH];
    logic [PW-1:0]     wr_reg, rd_reg;
    logic [CW-1:0]     cnt_reg;
    logic              push, pop;
    rarst_cmd_t        item;
    logic [IDX_W:0]    hi_clip;

    assign in_ready = (cnt_reg != CW'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = fifo_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // clip range to existing leaves, flag empty ranges
    always_comb
    begin
        hi_clip     = ({1'b0, range_high} > LAST) ? LAST : {1'b0, range_high};
        item.is_sum = (cmd == CMD_SUM);
        item.lo     = range_low;
        item.hi     = hi_clip[IDX_W-1:0];
        item.empty  = ({1'b0, range_low} > hi_clip);
        item.amt    = SUM_W'(add_amount);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

// ===== src/rarst_back.sv =====
`timescale 1ns / 1ps

// two binary-indexed trees (b1, b2): prefix(x) = x*B1(x) - B2(x)
// each add does up to two point updates on both trees, each sum up to two prefix queries
module rarst_back
    import rarst_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  rarst_cmd_t        q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SUM_W-1:0]  range_sum,
    output logic              busy
);

    localparam int AW = (LEAVES > 2) ? $clog2(LEAVES) : 1;
    localparam int XW = AW + 1;              // 1-based index, up to LEAVES
    localparam int MW = 32 + XW;
    localparam logic [XW-1:0] NMAX = XW'(LEAVES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL0  = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [SUM_W-1:0] b1_mem [LEAVES];
    logic [SUM_W-1:0] b2_mem [LEAVES];

    logic [2:0]        st_reg;
    rarst_cmd_t        c_reg;
    logic              pass_reg;        // 0: first point, 1: second point
    logic [XW-1:0]     x_reg;           // walking index, 1-based
    logic [XW-1:0]     f_reg;           // point factor for the multiplier
    logic [SUM_W-1:0]  d1_reg, d2_reg;  // deltas for update
    logic [SUM_W-1:0]  r1_reg, r2_reg;  // read data
    logic [SUM_W-1:0]  acc1_reg, acc2_reg;
    logic [SUM_W-1:0]  mlo_reg;         // low half partial product
    logic [SUM_W-1:0]  p_reg;           // x*B1 for a prefix
    logic [SUM_W-1:0]  res_reg;
    logic [AW-1:0]     addr;
    logic [XW-1:0]     lowbit;
    logic [XW:0]       x_up;
    logic [XW-1:0]     x_dn;
    logic [XW-1:0]     hi_1;
    logic              upd;
    logic [SUM_W-1:0]  m_src;
    logic [31:0]       m_half;
    logic [MW-1:0]     m_prod;
    logic [SUM_W-1:0]  prod;
    logic [SUM_W-1:0]  term;

    assign addr   = AW'(x_reg - XW'(1));
    assign lowbit = x_reg & (~x_reg + XW'(1));
    assign x_up   = {1'b0, x_reg} + {1'b0, lowbit};
    assign x_dn   = x_reg - lowbit;
    assign hi_1   = XW'(c_reg.hi) + XW'(1);
    assign upd    = !c_reg.is_sum;

    // low 64 bits of m_src * f_reg, one 32-bit half per cycle
    assign m_src  = c_reg.is_sum ? acc1_reg : d1_reg;
    assign m_half = (st_reg == S_MUL1) ? m_src[SUM_W-1:32] : m_src[31:0];
    assign m_prod = MW'(m_half) * MW'(f_reg);
    assign prod   = mlo_reg + {m_prod[31:0], 32'd0};
    assign term   = p_reg - acc2_reg;

    assign range_sum = res_reg;
    assign out_valid = (st_reg == S_OUT);
    assign q_ready   = (st_reg == S_IDLE);
    assign busy      = (st_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLEAR)
        begin
            b1_mem[addr] <= '0;
            b2_mem[addr] <= '0;
        end
        else if (st_reg == S_STEP && upd)
        begin
            b1_mem[addr] <= r1_reg + d1_reg;
            b2_mem[addr] <= r2_reg + d2_reg;
        end
        r1_reg <= b1_mem[addr];
        r2_reg <= b2_mem[addr];
    end

    // update points: l+1 gets (+amt, +amt*l), r+2 gets (-amt, -amt*(r+1))
    // query: prefix(r+1) minus prefix(l)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLEAR;
            c_reg    <= '0;
            pass_reg <= 1'b0;
            x_reg    <= XW'(1);
            f_reg    <= '0;
            d1_reg   <= '0;
            d2_reg   <= '0;
            acc1_reg <= '0;
            acc2_reg <= '0;
            mlo_reg  <= '0;
            p_reg    <= '0;
            res_reg  <= '0;
        end
        else
        begin
            case (st_reg)
                S_CLEAR:
                begin
                    x_reg <= x_reg + XW'(1);
                    if (x_reg == NMAX)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        c_reg    <= q_data;
                        pass_reg <= 1'b0;
                        res_reg  <= '0;
                        acc1_reg <= '0;
                        acc2_reg <= '0;
                        d1_reg   <= q_data.amt;
                        if (q_data.is_sum)
                        begin
                            x_reg <= XW'(q_data.hi) + XW'(1);
                            f_reg <= XW'(q_data.hi) + XW'(1);
                        end
                        else
                        begin
                            x_reg <= XW'(q_data.lo) + XW'(1);
                            f_reg <= XW'(q_data.lo);
                        end
                        if (q_data.empty)
                        begin
                            st_reg <= q_data.is_sum ? S_OUT : S_IDLE;
                        end
                        else
                        begin
                            st_reg <= q_data.is_sum ? S_RD : S_MUL0;
                        end
                    end
                end
                S_MUL0:
                begin
                    mlo_reg <= SUM_W'(m_prod);
                    st_reg  <= S_MUL1;
                end
                S_MUL1:
                begin
                    if (upd)
                    begin
                        d2_reg <= prod;
                        st_reg <= S_RD;
                    end
                    else
                    begin
                        p_reg  <= prod;
                        st_reg <= S_FIN;
                    end
                end
                S_RD:
                begin
                    st_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (upd)
                    begin
                        x_reg  <= x_up[XW-1:0];
                        st_reg <= (x_up > {1'b0, NMAX}) ? S_FIN : S_RD;
                    end
                    else
                    begin
                        acc1_reg <= acc1_reg + r1_reg;
                        acc2_reg <= acc2_reg + r2_reg;
                        x_reg    <= x_dn;
                        st_reg   <= (x_dn == '0) ? S_MUL0 : S_RD;
                    end
                end
                S_FIN:
                begin
                    if (!upd)
                    begin
                        res_reg <= pass_reg ? res_reg - term : res_reg + term;
                    end
                    if (!pass_reg && upd && hi_1 < NMAX)
                    begin
                        // second update point just past the range
                        pass_reg <= 1'b1;
                        d1_reg   <= '0 - c_reg.amt;
                        x_reg    <= hi_1 + XW'(1);
                        f_reg    <= hi_1;
                        st_reg   <= S_MUL0;
                    end
                    else if (!pass_reg && !upd && c_reg.lo != '0)
                    begin
                        // prefix below the range, subtracted
                        pass_reg <= 1'b1;
                        x_reg    <= XW'(c_reg.lo);
                        f_reg    <= XW'(c_reg.lo);
                        acc1_reg <= '0;
                        acc2_reg <= '0;
                        st_reg   <= S_RD;
                    end
                    else
                    begin
                        st_reg <= upd ? S_IDLE : S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
